>>> rtl/core/assert_macros.svh
// Assertion macros shared by the sorted list RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds whenever the trigger holds, same cycle.
`define ASSERT_SAME(name, clk, rst, trig, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Check that a condition holds in the cycle after the trigger.
`define ASSERT_NEXT(name, clk, rst, trig, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

>>> rtl/core/sli_pkg.sv
// Package for the sorted list core: field widths, operation and status codes,
// and the link struct passed between neighbouring cells. No dependencies.
package sli_pkg;

   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // What one cell shows its neighbours
   typedef struct packed {
      logic signed [VALUE_W-1:0] entry;    // stored value
      logic                      occupied; // cell holds a live entry
      logic                      less;     // live entry below the operand
      logic                      hit;      // a match seen at or left of this cell
   } cell_link_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic                      do_insert;
      logic                      do_delete;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

   // Boundary links at the two ends of the chain
   localparam cell_link_type HEAD_LINK = '{entry: '0, occupied: 1'b1, less: 1'b1, hit: 1'b0};
   localparam cell_link_type TAIL_LINK = '{entry: '0, occupied: 1'b0, less: 1'b0, hit: 1'b0};

endpackage

>>> rtl/core/sli_if.sv
// Request and response channel interfaces for the sorted list core.
// Depends on sli_pkg for field widths.
interface sli_req_if;
   import sli_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic signed [VALUE_W-1:0] value;
   logic [POS_W-1:0]          position;

   modport source (output valid, output op, output value, output position, input ready);
   modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface sli_rsp_if;
   import sli_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [COUNT_W-1:0]        entry_count;
   logic signed [VALUE_W-1:0] read_value;

   modport source (output valid, output status, output entry_count, output read_value,
                   input ready);
   modport sink   (input valid, input status, input entry_count, input read_value,
                   output ready);
endinterface

>>> rtl/core/sli_cell.sv
// One cell of the sorted chain: holds one entry and its occupied flag.
// Depends on sli_pkg for the link and command structs.
module sli_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  sli_pkg::cell_cmd_type  cmd,
   input  sli_pkg::cell_link_type left_link,
   input  sli_pkg::cell_link_type right_link,
   output sli_pkg::cell_link_type own_link
);
   import sli_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      occupied_ff, occupied_in;
   logic                      less, match;

   // Compare the live entry against the operand
   assign less  = occupied_ff && (entry_ff < cmd.value);
   assign match = occupied_ff && (entry_ff == cmd.value);

   assign own_link.entry    = entry_ff;
   assign own_link.occupied = occupied_ff;
   assign own_link.less     = less;
   assign own_link.hit      = left_link.hit | match;

   // Shift right on insert, left on delete, otherwise hold
   always_comb begin
      entry_in    = entry_ff;
      occupied_in = occupied_ff;
      if (cmd.do_insert && !less) begin
         occupied_in = left_link.occupied;
         entry_in    = left_link.less ? cmd.value : left_link.entry;
      end else if (cmd.do_delete && own_link.hit) begin
         occupied_in = right_link.occupied;
         entry_in    = right_link.entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         occupied_ff <= 1'b0;
      end else begin
         occupied_ff <= occupied_in;
      end
   end

endmodule

>>> rtl/core/sorted_list_insert_delete_core.sv
// Top level of the sorted list core: a chain of sli_cell entries plus the
// occupancy counter and response register. Depends on sli_pkg, sli_if, sli_cell, assert_macros.svh.
//
//   channel   role   handshake     payload
//   req_chan  in     valid/ready   op, value, position
//   rsp_chan  out    valid/ready   status, entry_count, read_value
//
// One operation a cycle unless req_chan stalls: every cell compares and shifts in the
// cycle of acceptance, and the response lands in the output register on the next edge.
// Delete carries its match flag through the cells, so that ripple sets the path.
// Synchronous reset empties the list; no clearing pass.
// req_chan stalls only while a response waits and rsp_chan.ready is low.
module sorted_list_insert_delete_core #(
   parameter int DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   sli_req_if.sink   req_chan,
   sli_rsp_if.source rsp_chan
);
   import sli_pkg::*;

   `include "assert_macros.svh"

   localparam int CntW  = $clog2(DEPTH + 1);
   localparam int CmpW  = (CntW > POS_W) ? CntW : POS_W;
   localparam int WideW = (CntW > COUNT_W) ? CntW : COUNT_W;
   localparam int ReadN = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

   cell_link_type link       [DEPTH];
   cell_link_type left_links [DEPTH];
   cell_link_type right_links[DEPTH];
   cell_cmd_type  cmd;

   logic [CntW-1:0]           count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic [COUNT_W-1:0]        entry_count_ff, entry_count_in;
   logic signed [VALUE_W-1:0] read_value_ff, read_value_in;
   logic signed [VALUE_W-1:0] read_sel;
   logic [WideW-1:0]          count_wide;
   logic                      accept, full, found;

   // Build the chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_links[i] = HEAD_LINK;
      end else begin : g_mid_l
         assign left_links[i] = link[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_links[i] = TAIL_LINK;
      end else begin : g_mid_r
         assign right_links[i] = link[i+1];
      end
      sli_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (left_links[i]),
         .right_link (right_links[i]),
         .own_link   (link[i])
      );
   end

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == CntW'(DEPTH));
   assign found          = link[DEPTH-1].hit;

   // Select the entry at the requested position
   always_comb begin
      read_sel = '0;
      for (int k = 0; k < ReadN; k++) begin
         if (req_chan.position == POS_W'(k)) begin
            read_sel = link[k].entry;
         end
      end
   end

   // Decode the operation and work out the response
   always_comb begin
      cmd.do_insert = 1'b0;
      cmd.do_delete = 1'b0;
      cmd.value     = req_chan.value;
      count_in      = count_ff;
      status_in     = ST_NOT_FOUND;
      read_value_in = '0;
      case (req_chan.op)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in     = ST_DONE;
               cmd.do_insert = accept;
               count_in      = count_ff + CntW'(1);
            end
         end
         OP_DELETE: begin
            if (found) begin
               status_in     = ST_DONE;
               cmd.do_delete = accept;
               count_in      = count_ff - CntW'(1);
            end
         end
         OP_READ: begin
            if (CmpW'(req_chan.position) < CmpW'(count_ff)) begin
               status_in     = ST_DONE;
               read_value_in = read_sel;
            end
         end
         default: begin
            status_in = ST_NOT_FOUND;
         end
      endcase
      count_wide     = WideW'(count_in);
      entry_count_in = count_wide[COUNT_W-1:0];
   end

   // Hold the response until taken
   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         entry_count_ff <= entry_count_in;
         read_value_ff  <= read_value_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.entry_count = entry_count_ff;
   assign rsp_chan.read_value  = read_value_ff;

   // Counter and cell occupancy agree at the head and the tail
   `ASSERT_SAME(a_head_occ, clock, reset, 1'b1, ((count_ff != '0) == link[0].occupied), "head occupancy disagrees with count")
   `ASSERT_SAME(a_tail_occ, clock, reset, 1'b1, (full == link[DEPTH-1].occupied), "tail occupancy disagrees with full")
   // A successful insert grows the list by one
   `ASSERT_NEXT(a_ins_grow, clock, reset, (cmd.do_insert), (count_ff == $past(count_ff) + CntW'(1)), "insert did not grow the count")
   // Only a successful read returns a non-zero value
   `ASSERT_SAME(a_rv_zero, clock, reset, (rsp_valid_ff && status_ff != ST_DONE), (read_value_ff == '0), "read value set on failed transaction")

endmodule
